@@ hdl/lsdrs_pkg.sv @@
// Package for the decimal LSD radix sorter: sizes, payload structs, states.
// No dependencies.
`timescale 1ns / 1ps
package lsdrs_pkg;
    localparam int MAX_KEYS  = 64;
    localparam int KEY_W     = 31;
    localparam int IDX_W     = $clog2(MAX_KEYS);
    localparam int CNT_W     = $clog2(MAX_KEYS + 1);
    localparam int RADIX     = 10;
    localparam int DIG_W     = 4;
    localparam int PLACE_W   = 34;
    localparam int MAX_PASS  = 10;

    typedef struct packed {
        logic [KEY_W-1:0] key_value;
        logic             last_item;
    } in_item_t;

    typedef struct packed {
        logic [KEY_W-1:0] sorted_value;
        logic             last_result;
        logic             overflowed;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_MAX,
        ST_CLEAR,
        ST_COUNT,
        ST_PREFIX,
        ST_SCATTER,
        ST_COPY,
        ST_EMIT,
        ST_EMIT_WAIT
    } state_t;

    // Scale factor 10^p for pass p, as a constant table
    function automatic logic [PLACE_W-1:0] place_of(input logic [DIG_W-1:0] p);
        logic [PLACE_W-1:0] v;
        case (p)
            4'd0:    v = 34'd1;
            4'd1:    v = 34'd10;
            4'd2:    v = 34'd100;
            4'd3:    v = 34'd1000;
            4'd4:    v = 34'd10000;
            4'd5:    v = 34'd100000;
            4'd6:    v = 34'd1000000;
            4'd7:    v = 34'd10000000;
            4'd8:    v = 34'd100000000;
            4'd9:    v = 34'd1000000000;
            default: v = 34'd10000000000;
        endcase
        return v;
    endfunction
endpackage

@@ hdl/lsd_decimal_radix_sort_top.sv @@
// Top level of the decimal LSD radix sorter.
// Depends on lsdrs_pkg, lsdrs_ram, lsdrs_digit.
`timescale 1ns / 1ps
// Keys are loaded one item per cycle, while no result is pending, into a
// 64-entry store until an item marked last arrives; keys beyond 64 are
// dropped and flagged on every result. The block then stops taking items,
// finds the maximum, counts its decimal digits and runs one pass per digit
// (up to ten). A pass counts digits, forms prefix sums, scatters from last
// to first into a scratch store and copies back. Every digit goes through
// one shared divide-by-ten unit that repeats p times on pass p, so the
// digit count of the largest key sets the time. Results then stream out in
// sorted order, held under output backpressure.
module lsd_decimal_radix_sort_top
    import lsdrs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);
    state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             ovf_reg, ovf_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [DIG_W-1:0] pass_reg, pass_next;
    logic [DIG_W-1:0] npass_reg, npass_next;
    logic [KEY_W-1:0] max_reg, max_next;
    logic [CNT_W-1:0] hist_reg [RADIX];
    logic [CNT_W-1:0] hist_next [RADIX];
    logic [1:0]       ph_reg, ph_next;
    logic             ov_reg, ov_next;
    out_item_t        od_reg, od_next;

    logic             k_we, s_we;
    logic [IDX_W-1:0] k_wa, k_ra, s_wa, s_ra;
    logic [KEY_W-1:0] k_wd, k_rd, s_wd, s_rd;
    logic             d_start, d_done;
    logic [DIG_W-1:0] d_digit;

    lsdrs_ram #(.WIDTH(KEY_W), .DEPTH(MAX_KEYS)) u_key (
        .clk(clk), .we(k_we), .waddr(k_wa), .wdata(k_wd), .raddr(k_ra), .rdata(k_rd));
    lsdrs_ram #(.WIDTH(KEY_W), .DEPTH(MAX_KEYS)) u_scr (
        .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));
    lsdrs_digit u_dig (
        .clk(clk), .rst_n(rst_n), .start(d_start), .key(k_rd), .pass(pass_reg),
        .done(d_done), .digit(d_digit));

    assign in_ready  = (state_reg == ST_LOAD) && !ov_reg;
    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    // Sequencer: next state, store addresses and histogram updates
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        i_next     = i_reg;
        pass_next  = pass_reg;
        npass_next = npass_reg;
        max_next   = max_reg;
        hist_next  = hist_reg;
        ph_next    = ph_reg;
        ov_next    = ov_reg;
        od_next    = od_reg;
        k_we = 1'b0; k_wa = IDX_W'(cnt_reg); k_wd = in_data.key_value;
        k_ra = IDX_W'(i_reg);
        s_we = 1'b0; s_wa = '0; s_wd = k_rd;
        s_ra = IDX_W'(i_reg);
        d_start = 1'b0;
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_valid && in_ready)
                begin
                    if (cnt_reg < CNT_W'(MAX_KEYS))
                    begin
                        k_we     = 1'b1;
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                    else
                        ovf_next = 1'b1;
                    if (in_data.last_item)
                    begin
                        state_next = ST_MAX;
                        i_next     = '0;
                        ph_next    = '0;
                        max_next   = '0;
                    end
                end
            end
            ST_MAX:
            begin
                // Read address i, data appears next cycle
                if (ph_reg != 2'd0 && k_rd > max_reg)
                    max_next = k_rd;
                ph_next = 2'd1;
                if (i_reg == cnt_reg)
                begin
                    if (ph_reg != 2'd0)
                    begin
                        state_next = ST_CLEAR;
                        pass_next  = '0;
                        npass_next = '0;
                    end
                end
                else
                    i_next = i_reg + CNT_W'(1);
                if (i_reg == cnt_reg && ph_reg == 2'd0)
                    ph_next = 2'd1;
            end
            ST_CLEAR:
            begin
                // Count passes needed (digits of the maximum), then clear the histogram or go to output
                if (npass_reg < DIG_W'(MAX_PASS) &&
                    {3'b0, max_reg} >= place_of(npass_reg))
                    npass_next = npass_reg + DIG_W'(1);
                else if (pass_reg >= npass_reg)
                begin
                    state_next = ST_EMIT;
                    i_next     = '0;
                    ph_next    = '0;
                end
                else
                begin
                    for (int d = 0; d < RADIX; d++)
                        hist_next[d] = '0;
                    i_next     = '0;
                    ph_next    = '0;
                    state_next = ST_COUNT;
                end
            end
            ST_COUNT:
            begin
                // ph 0: address; ph 1: start divider; ph 2: wait for digit
                if (i_reg == cnt_reg)
                begin
                    state_next = ST_PREFIX;
                    i_next     = CNT_W'(1);
                end
                else if (ph_reg == 2'd0)
                    ph_next = 2'd1;
                else if (ph_reg == 2'd1)
                begin
                    d_start = 1'b1;
                    ph_next = 2'd2;
                end
                else if (d_done)
                begin
                    hist_next[d_digit] = hist_reg[d_digit] + CNT_W'(1);
                    i_next  = i_reg + CNT_W'(1);
                    ph_next = 2'd0;
                end
            end
            ST_PREFIX:
            begin
                hist_next[DIG_W'(i_reg)] = hist_reg[DIG_W'(i_reg)] +
                                           hist_reg[DIG_W'(i_reg - CNT_W'(1))];
                if (i_reg == CNT_W'(RADIX - 1))
                begin
                    state_next = ST_SCATTER;
                    i_next     = cnt_reg;
                    ph_next    = '0;
                end
                else
                    i_next = i_reg + CNT_W'(1);
            end
            ST_SCATTER:
            begin
                k_ra = IDX_W'(i_reg - CNT_W'(1));
                if (i_reg == '0)
                begin
                    state_next = ST_COPY;
                    ph_next    = '0;
                end
                else if (ph_reg == 2'd0)
                    ph_next = 2'd1;
                else if (ph_reg == 2'd1)
                begin
                    d_start = 1'b1;
                    ph_next = 2'd2;
                end
                else if (d_done)
                begin
                    s_we = 1'b1;
                    s_wa = IDX_W'(hist_reg[d_digit] - CNT_W'(1));
                    hist_next[d_digit] = hist_reg[d_digit] - CNT_W'(1);
                    i_next  = i_reg - CNT_W'(1);
                    ph_next = 2'd0;
                end
            end
            ST_COPY:
            begin
                // Read scratch at i, write the word read at i-1 to key store at i-1
                k_wa = IDX_W'(i_reg - CNT_W'(1));
                k_wd = s_rd;
                if (ph_reg != 2'd0)
                    k_we = 1'b1;
                ph_next = 2'd1;
                if (i_reg == cnt_reg && ph_reg != 2'd0)
                begin
                    state_next = ST_CLEAR;
                    pass_next  = pass_reg + DIG_W'(1);
                end
                else
                    i_next = i_reg + CNT_W'(1);
                if (ph_reg == 2'd0)
                    i_next = i_reg + CNT_W'(1);
                s_ra = IDX_W'(i_reg);
            end
            ST_EMIT:
            begin
                // Address issued; data valid next cycle
                state_next = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next = 1'b1;
                    od_next.sorted_value = k_rd;
                    od_next.last_result  = (i_reg + CNT_W'(1) == cnt_reg);
                    od_next.overflowed   = ovf_reg;
                    if (i_reg + CNT_W'(1) == cnt_reg)
                    begin
                        state_next = ST_LOAD;
                        cnt_next   = '0;
                        ovf_next   = 1'b0;
                    end
                    else
                    begin
                        i_next     = i_reg + CNT_W'(1);
                        state_next = ST_EMIT;
                    end
                end
            end
            default:
                state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            ov_reg    <= 1'b0;
            i_reg     <= '0;
            ph_reg    <= '0;
            pass_reg  <= '0;
            npass_reg <= '0;
            for (int d = 0; d < RADIX; d++)
                hist_reg[d] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
            ov_reg    <= ov_next;
            i_reg     <= i_next;
            ph_reg    <= ph_next;
            pass_reg  <= pass_next;
            npass_reg <= npass_next;
            hist_reg  <= hist_next;
        end
    end

    always_ff @(posedge clk)
    begin
        max_reg <= max_next;
        od_reg  <= od_next;
    end
endmodule

@@ hdl/lsdrs_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module lsdrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

@@ hdl/lsdrs_digit.sv @@
// Multi-cycle decimal digit extractor: divides by ten p times, then takes mod 10.
// Depends on lsdrs_pkg.
`timescale 1ns / 1ps
module lsdrs_digit
    import lsdrs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [KEY_W-1:0]   key,
    input  logic [DIG_W-1:0]   pass,
    output logic               done,
    output logic [DIG_W-1:0]   digit
);
    logic [KEY_W-1:0]   val_reg, val_next;
    logic [DIG_W-1:0]   cnt_reg, cnt_next;
    logic [DIG_W-1:0]   dig_reg, dig_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [KEY_W-1:0]   q10;

    // Divide by ten through a reciprocal multiplication
    assign q10 = KEY_W'((64'(val_reg) * 64'd3435973837) >> 35);

    // Shift out one decimal digit per cycle, then keep the remainder
    always_comb
    begin
        val_next  = val_reg;
        cnt_next  = cnt_reg;
        dig_next  = dig_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            val_next  = key;
            cnt_next  = pass;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                dig_next  = DIG_W'(val_reg - KEY_W'(q10 * KEY_W'(10)));
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                val_next = q10;
                cnt_next = cnt_reg - DIG_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        cnt_reg <= cnt_next;
        dig_reg <= dig_next;
    end

    assign done  = done_reg;
    assign digit = dig_reg;
endmodule

@@ hdl/lsdrs_checker.sv @@
// Port-level assertions for the radix sorter, bound to the top level.
// Depends on lsdrs_pkg and lsd_decimal_radix_sort_top.
`timescale 1ns / 1ps
module lsdrs_checker
    import lsdrs_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input in_item_t  in_data,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);
    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // No item accepted while results stream out
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input ready during output");

    // Last item closes the set: block stops taking items
    a_last_stops: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.last_item |=> !in_ready)
        else $error("ready after last item");

    // After the final result the block is ready again
    a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_data.last_result |=> in_ready)
        else $error("not ready after final result");
endmodule

bind lsd_decimal_radix_sort_top lsdrs_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data));
